// ===== hdl/serial_frame_classifier_assert.svh =====
// assertion macros shared by the serial frame classifier modules
`ifndef SERIAL_FRAME_CLASSIFIER_ASSERT_SVH
`define SERIAL_FRAME_CLASSIFIER_ASSERT_SVH

// checked on every clock edge, held off while reset is asserted
`define SFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge after the reset edge itself
`define SFC_ASSERT_POST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) $past(rst_n) |-> prop) else $error(msg);

`endif

// ===== hdl/sfc_pkg.sv =====
// shared types and constants of the serial frame classifier
`timescale 1ns / 1ps
`default_nettype none

package sfc_pkg;

  localparam int BUFFER_BYTES = 256;
  localparam int HEAD_DEPTH   = 17;
  localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  localparam logic [7:0] BCAST_ADDR  = 8'hFF;
  localparam logic [7:0] FN_READ     = 8'h03;
  localparam logic [7:0] FN_WRITE    = 8'h10;
  localparam logic [7:0] UPG_START   = 8'h55;
  localparam logic [7:0] UPG_END     = 8'hAA;
  localparam logic [7:0] CH_HASH     = 8'h23;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_A        = 8'h41;
  localparam logic [7:0] CH_T        = 8'h54;
  localparam logic [7:0]  DEV_ADDR_RST  = 8'd1;
  localparam logic [15:0] IDLE_LIM_RST  = 16'd50;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_DEV_ADDR = 1'b0,
    REG_IDLE_LIM = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    KIND_UNKNOWN = 3'd0,
    KIND_AT      = 3'd1,
    KIND_MB_OK   = 3'd2,
    KIND_MB_BAD  = 3'd3,
    KIND_UPG_OK  = 3'd4,
    KIND_UPG_BAD = 3'd5
  } frame_kind_t;

  // everything the back end needs to classify one ended frame
  typedef struct packed {
    logic [HEAD_DEPTH-1:0][7:0] head;
    logic [15:0]                crc;
    logic [7:0]                 last1;
    logic [7:0]                 last0;
    logic [CNT_W-1:0]           count;
  } frame_snap_t;

endpackage

`default_nettype wire

// ===== hdl/sfc_front.sv =====
// front end: takes bytes and ticks, keeps frame state, emits a snapshot at frame end
`timescale 1ns / 1ps
`default_nettype none

module sfc_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_command,
  input  wire logic [7:0]           in_rx_byte,
  input  wire logic [15:0]          idle_limit,
  input  wire logic                 q_full,
  output logic                      q_push,
  output sfc_pkg::frame_snap_t      q_data
);

  logic [sfc_pkg::HEAD_DEPTH-1:0][7:0] head_r, head_nxt;
  logic [sfc_pkg::CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [15:0]                         crc_r, crc_nxt;
  logic [7:0]                          last0_r, last0_nxt;
  logic [7:0]                          last1_r, last1_nxt;
  logic                                armed_r, armed_nxt;
  logic [15:0]                         cd_r, cd_nxt;
  logic                                accept;
  logic                                frame_end;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ sfc_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign frame_end = accept && (in_command == sfc_pkg::CMD_TICK) && armed_r && (cd_r <= 16'd1);
  assign q_push    = frame_end;

  always_comb begin
    q_data.head  = head_r;
    q_data.crc   = crc_r;
    q_data.last1 = last1_r;
    q_data.last0 = last0_r;
    q_data.count = cnt_r;
  end

  always_comb begin
    head_nxt  = head_r;
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    last0_nxt = last0_r;
    last1_nxt = last1_r;
    armed_nxt = armed_r;
    cd_nxt    = cd_r;
    if (accept) begin
      if (in_command == sfc_pkg::CMD_BYTE) begin
        if (cnt_r < sfc_pkg::CNT_W'(sfc_pkg::BUFFER_BYTES)) begin
          for (int i = 0; i < sfc_pkg::HEAD_DEPTH; i++) begin
            if (cnt_r == sfc_pkg::CNT_W'(i)) head_nxt[i] = in_rx_byte;
          end
          // crc trails two bytes behind so the received crc stays out of it
          if (cnt_r >= sfc_pkg::CNT_W'(2)) crc_nxt = crc_feed(crc_r, last0_r);
          last0_nxt = last1_r;
          last1_nxt = in_rx_byte;
          cnt_nxt   = cnt_r + sfc_pkg::CNT_W'(1);
          armed_nxt = 1'b1;
          cd_nxt    = idle_limit;
        end else begin
          // overflow: drop word, restart count, keep header and timer
          cnt_nxt   = '0;
          crc_nxt   = sfc_pkg::CRC_INIT;
          last0_nxt = '0;
          last1_nxt = '0;
        end
      end else if (armed_r) begin
        if (cd_r > 16'd1) begin
          cd_nxt = cd_r - 16'd1;
        end else begin
          head_nxt  = '0;
          cnt_nxt   = '0;
          crc_nxt   = sfc_pkg::CRC_INIT;
          last0_nxt = '0;
          last1_nxt = '0;
          armed_nxt = 1'b0;
          cd_nxt    = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      cnt_r   <= '0;
      crc_r   <= sfc_pkg::CRC_INIT;
      last0_r <= '0;
      last1_r <= '0;
      armed_r <= 1'b0;
      cd_r    <= '0;
    end else begin
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      last0_r <= last0_nxt;
      last1_r <= last1_nxt;
      armed_r <= armed_nxt;
      cd_r    <= cd_nxt;
    end
  end

`include "serial_frame_classifier_assert.svh"

  `SFC_ASSERT(a_idle_empty, (!armed_r |-> cnt_r == '0), "count nonzero while timer idle")

endmodule

`default_nettype wire

// ===== hdl/sfc_fifo.sv =====
// short queue of frame snapshots between front and back end
`timescale 1ns / 1ps
`default_nettype none

module sfc_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire sfc_pkg::frame_snap_t push_data,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      pop_valid,
  output sfc_pkg::frame_snap_t      pop_data
);

  sfc_pkg::frame_snap_t            mem_r [sfc_pkg::QDEPTH];
  logic [sfc_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [sfc_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [sfc_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  logic                            do_push, do_pop;

  assign full      = (cnt_r == sfc_pkg::QCNT_W'(sfc_pkg::QDEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  function automatic logic [sfc_pkg::QPTR_W-1:0] ptr_inc(input logic [sfc_pkg::QPTR_W-1:0] p);
    return (p == sfc_pkg::QPTR_W'(sfc_pkg::QDEPTH - 1)) ? '0 : p + sfc_pkg::QPTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + sfc_pkg::QCNT_W'(1);
    else if (!do_push && do_pop) cnt_nxt = cnt_r - sfc_pkg::QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`include "serial_frame_classifier_assert.svh"

  `SFC_ASSERT(a_no_drop, (push |-> !full), "snapshot pushed into full queue")

endmodule

`default_nettype wire

// ===== hdl/sfc_back.sv =====
// back end: classifies a queued frame and holds the result word for the output
`timescale 1ns / 1ps
`default_nettype none

module sfc_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [7:0]           device_address,
  input  wire logic                 q_valid,
  input  wire sfc_pkg::frame_snap_t q_data,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [2:0]                out_frame_kind,
  output logic [sfc_pkg::CNT_W-1:0] out_frame_length,
  output logic                      out_is_broadcast
);

  sfc_pkg::frame_kind_t      kind, kind_r;
  logic                      bcast, bcast_r;
  logic [sfc_pkg::CNT_W-1:0] len_r;
  logic                      valid_r, valid_nxt;
  logic [7:0]                sum;
  logic                      is_at, is_mb, is_upg, crc_ok;
  logic [sfc_pkg::HEAD_DEPTH-1:0][7:0] h;

  assign h = q_data.head;

  always_comb begin
    sum = '0;
    for (int i = 4; i < 12; i++) begin
      sum = sum + h[i];
    end
  end

  assign is_at  = (h[0] == sfc_pkg::CH_A) && (h[1] == sfc_pkg::CH_T);
  assign is_mb  = ((h[0] == device_address) || (h[0] == sfc_pkg::BCAST_ADDR)) &&
                  ((h[1] == sfc_pkg::FN_READ) || (h[1] == sfc_pkg::FN_WRITE));
  assign is_upg = (h[0] == sfc_pkg::UPG_START) && (h[1] == sfc_pkg::UPG_START) &&
                  (h[2] == sfc_pkg::CH_HASH) && (h[3] == sfc_pkg::CH_HASH) &&
                  (h[13] == sfc_pkg::CH_STAR) && (h[14] == sfc_pkg::CH_STAR) &&
                  (h[15] == sfc_pkg::UPG_END) && (h[16] == sfc_pkg::UPG_END);
  // received crc arrives low byte first
  assign crc_ok = (q_data.count >= sfc_pkg::CNT_W'(2)) &&
                  ({q_data.last1, q_data.last0} == q_data.crc);

  always_comb begin
    kind  = sfc_pkg::KIND_UNKNOWN;
    bcast = 1'b0;
    if (is_at) begin
      kind = sfc_pkg::KIND_AT;
    end else if (is_mb) begin
      kind  = crc_ok ? sfc_pkg::KIND_MB_OK : sfc_pkg::KIND_MB_BAD;
      bcast = (h[0] == sfc_pkg::BCAST_ADDR);
    end else if (is_upg) begin
      kind = (sum == h[12]) ? sfc_pkg::KIND_UPG_OK : sfc_pkg::KIND_UPG_BAD;
    end
  end

  assign q_pop     = q_valid && (!valid_r || out_ready);
  assign valid_nxt = q_pop ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r  <= kind;
      bcast_r <= bcast;
      len_r   <= q_data.count;
    end
  end

  assign out_valid        = valid_r;
  assign out_frame_kind   = kind_r;
  assign out_frame_length = len_r;
  assign out_is_broadcast = bcast_r;

`include "serial_frame_classifier_assert.svh"

  `SFC_ASSERT(a_bcast_mb, (valid_r && bcast_r |-> (kind_r == sfc_pkg::KIND_MB_OK || kind_r == sfc_pkg::KIND_MB_BAD)), "broadcast flag on non modbus frame")
  `SFC_ASSERT(a_short_mb, (valid_r && kind_r == sfc_pkg::KIND_MB_OK |-> len_r >= sfc_pkg::CNT_W'(2)), "modbus ok with under two bytes")

endmodule

`default_nettype wire

// ===== hdl/serial_frame_classifier.sv =====
// top level: register port, front end, snapshot queue and back end
//
//  channel  | signals                                    | moves
//  ---------+--------------------------------------------+------------------------------
//  in_      | in_valid/in_ready, in_command, in_rx_byte  | one byte or one tick per word
//  out_     | out_valid/out_ready, kind, length, bcast   | one result word per ended frame
//  cfg_     | psel/penable/pwrite/paddr/pwdata/prdata    | device_address, idle_limit
//
// one input word per cycle while in_ready is high; the crc byte step is unrolled in the front end
// a result word passes through the snapshot queue and the back end register after the tick that ends the frame
// reset is synchronous, active low; no clearing pass is needed
// in_ready drops only when the two-entry snapshot queue is full
// a stalled output holds the back end register; the queue absorbs two more frames
`timescale 1ns / 1ps
`default_nettype none

module serial_frame_classifier (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_command,
  input  wire logic [7:0]           in_rx_byte,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [2:0]                out_frame_kind,
  output logic [8:0]                out_frame_length,
  output logic                      out_is_broadcast,
  input  wire logic                 cfg_psel,
  input  wire logic                 cfg_penable,
  input  wire logic                 cfg_pwrite,
  input  wire logic [2:0]           cfg_paddr,
  input  wire logic [31:0]          cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);

  logic [7:0]           dev_addr_r;
  logic [15:0]          idle_lim_r;
  logic                 cfg_wr;
  sfc_pkg::reg_idx_t    reg_idx;
  logic                 q_full, q_push, q_pop, q_valid;
  sfc_pkg::frame_snap_t q_in, q_out;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  // registers sit on word addresses, low address bits are ignored
  assign reg_idx    = sfc_pkg::reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= sfc_pkg::DEV_ADDR_RST;
      idle_lim_r <= sfc_pkg::IDLE_LIM_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        sfc_pkg::REG_DEV_ADDR: dev_addr_r <= cfg_pwdata[7:0];
        sfc_pkg::REG_IDLE_LIM: idle_lim_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sfc_pkg::REG_DEV_ADDR: cfg_prdata = {24'h000000, dev_addr_r};
      sfc_pkg::REG_IDLE_LIM: cfg_prdata = {16'h0000, idle_lim_r};
      default:               cfg_prdata = '0;
    endcase
  end

  sfc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .in_rx_byte (in_rx_byte),
    .idle_limit (idle_lim_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  sfc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_out)
  );

  sfc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .device_address   (dev_addr_r),
    .q_valid          (q_valid),
    .q_data           (q_out),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_kind   (out_frame_kind),
    .out_frame_length (out_frame_length),
    .out_is_broadcast (out_is_broadcast)
  );

endmodule

`default_nettype wire
